[rtl/core/wsa_pkg.sv]
package wsa_pkg;

	// Field and state widths
	localparam int SAMPLE_W     = 24;
	localparam int WINDOW_DEPTH = 64;
	localparam int ADDR_W       = $clog2(WINDOW_DEPTH);
	localparam int CNT_W        = ADDR_W + 1;
	localparam int SUM_W        = SAMPLE_W + ADDR_W;
	localparam int SQ_W         = 2 * SAMPLE_W - 1 + ADDR_W;
	localparam int NUM_W        = SQ_W + ADDR_W;
	localparam int VAR_W        = 47;
	localparam int LIMIT_W      = 28;
	localparam int GRID_W       = 16;
	localparam int GRID_LINES   = 4;
	localparam int MUL_W        = 31;
	localparam int PROD_W       = 2 * MUL_W;
	localparam int DIV_N        = 26;
	localparam int DIV_D        = 22;
	localparam int DIV_CNT_W    = $clog2(DIV_N);

	// Configuration port
	localparam int CFG_W     = 5;
	localparam int CFG_IDX_W = 1;
	localparam logic [CFG_IDX_W-1:0] REG_GROW   = 1'b0;
	localparam logic [CFG_IDX_W-1:0] REG_SHRINK = 1'b1;
	localparam logic [4:0] GROW_RESET   = 5'd11;
	localparam logic [3:0] SHRINK_RESET = 4'd3;

	// Scale codes
	localparam logic [1:0] MANT_1 = 2'd0;
	localparam logic [1:0] MANT_2 = 2'd1;
	localparam logic [1:0] MANT_5 = 2'd2;
	localparam logic [2:0] DEC_TOP = 3'd4;

	typedef struct packed {
		logic [1:0] mant;
		logic [2:0] dec;
	} scale_t;

	typedef struct packed {
		scale_t sc;
		logic   sat;
	} step_res_t;

	typedef struct packed {
		logic                       we;
		logic [ADDR_W-1:0]          addr;
		logic signed [SAMPLE_W-1:0] wdata;
	} mem_req_t;

	typedef struct packed {
		logic             start;
		logic [DIV_N-1:0] dividend;
		logic [DIV_D-1:0] divisor;
	} div_req_t;

	typedef struct packed {
		logic             done;
		logic [DIV_N-1:0] quotient;
	} div_rsp_t;

	typedef enum logic [4:0] {
		ST_IDLE, ST_P_RD, ST_P_SS, ST_P_OO, ST_P_UPD,
		ST_E_SCAN, ST_E_GMUL, ST_E_SMUL, ST_E_STEP,
		ST_E_TTEST, ST_E_TDIV, ST_E_TMUL, ST_E_TSET,
		ST_E_BTEST, ST_E_BDIV, ST_E_BMUL, ST_E_BSET,
		ST_F_SQ, ST_F_OUT
	} state_t;

	// Grid value in whole units from the scale codes
	function automatic logic [GRID_W-1:0] grid_value(scale_t s);
		logic [2:0]  mv;
		logic [13:0] dv;
		case (s.mant)
			MANT_2:  mv = 3'd2;
			MANT_5:  mv = 3'd5;
			default: mv = 3'd1;
		endcase
		case (s.dec)
			3'd0:    dv = 14'd1;
			3'd1:    dv = 14'd10;
			3'd2:    dv = 14'd100;
			3'd3:    dv = 14'd1000;
			default: dv = 14'd10000;
		endcase
		return GRID_W'(mv * dv);
	endfunction

	function automatic step_res_t step_up(scale_t s);
		step_res_t r;
		r.sc  = s;
		r.sat = 1'b0;
		if (s.mant == MANT_1) begin
			r.sc.mant = MANT_2;
		end else if (s.mant == MANT_2) begin
			r.sc.mant = MANT_5;
		end else if (s.dec >= DEC_TOP) begin
			r.sc.mant = MANT_5;
			r.sc.dec  = DEC_TOP;
			r.sat     = 1'b1;
		end else begin
			r.sc.mant = MANT_1;
			r.sc.dec  = s.dec + 3'd1;
		end
		return r;
	endfunction

	function automatic scale_t step_down(scale_t s);
		scale_t r;
		r = s;
		if (s.mant == MANT_5) begin
			r.mant = MANT_2;
		end else if (s.mant == MANT_2) begin
			r.mant = MANT_1;
		end else if (s.dec == 3'd0) begin
			r.mant = MANT_1;
		end else begin
			r.mant = MANT_5;
			r.dec  = s.dec - 3'd1;
		end
		return r;
	endfunction

endpackage

[rtl/core/wsa_window.sv]
module wsa_window (
	input  logic                                clk,
	input  logic                                arst_n,
	input  wsa_pkg::mem_req_t                   req,
	output logic signed [wsa_pkg::SAMPLE_W-1:0] rd_value
);

	logic signed [wsa_pkg::SAMPLE_W-1:0] store [wsa_pkg::WINDOW_DEPTH];
	logic signed [wsa_pkg::SAMPLE_W-1:0] rdata_q;
	logic [wsa_pkg::WINDOW_DEPTH-1:0]    vld_q;
	logic                                rvld_q;

	// Write and registered read of the sample store
	always_ff @(posedge clk) begin
		if (req.we) begin
			store[req.addr] <= req.wdata;
		end
		rdata_q <= store[req.addr];
	end

	// Track written entries; unwritten ones read as zero
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q  <= '0;
			rvld_q <= 1'b0;
		end else begin
			if (req.we) begin
				vld_q[req.addr] <= 1'b1;
			end
			rvld_q <= vld_q[req.addr];
		end
	end

	assign rd_value = rvld_q ? rdata_q : '0;

endmodule

[rtl/core/wsa_divider.sv]
module wsa_divider (
	input  logic              clk,
	input  logic              arst_n,
	input  wsa_pkg::div_req_t req,
	output wsa_pkg::div_rsp_t rsp
);

	logic [wsa_pkg::DIV_D:0]        rem_q;
	logic [wsa_pkg::DIV_N-1:0]      quo_q;
	logic [wsa_pkg::DIV_D-1:0]      dvs_q;
	logic [wsa_pkg::DIV_CNT_W-1:0]  cnt_q;
	logic                           busy_q;
	logic                           done_q;
	logic [wsa_pkg::DIV_D:0]        trial;
	logic                           fits;

	// One restoring step: shift in the next dividend bit and try the subtract
	assign trial = {rem_q[wsa_pkg::DIV_D-1:0], quo_q[wsa_pkg::DIV_N-1]};
	assign fits  = trial >= {1'b0, dvs_q};

	always_ff @(posedge clk) begin
		if (req.start) begin
			rem_q <= '0;
			quo_q <= req.dividend;
			dvs_q <= req.divisor;
		end else if (busy_q) begin
			rem_q <= fits ? trial - {1'b0, dvs_q} : trial;
			quo_q <= {quo_q[wsa_pkg::DIV_N-2:0], fits};
		end
	end

	// Step counter and completion pulse
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= '0;
			busy_q <= 1'b0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				cnt_q  <= '0;
				busy_q <= 1'b1;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == wsa_pkg::DIV_CNT_W'(wsa_pkg::DIV_N - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	assign rsp.done     = done_q;
	assign rsp.quotient = quo_q;

endmodule

[rtl/core/window_stats_autorange.sv]
// Window statistics with 1-2-5 autoranging axis.
// Input channel (in_valid/in_ready): opcode 0 pushes sample into a 64-entry
// window, opcode 1 evaluates min/max, scale and axis limits. Output channel
// (out_valid/out_ready) returns one result transaction per input.
// Configuration: cfg_we writes cfg_data into register cfg_index (0 grow
// threshold, 1 shrink threshold) in the same cycle; the user must write
// only while idle, as the block does not enforce it. Steps: a push reads
// the oldest entry, squares the new and old samples and updates the window
// and sums; an evaluate scans the window, steps the scale and runs the
// 26-step divider for each axis limit that moves. Throughput: one item at
// a time; the sequencer and one shared 31x31 multiplier carry every item,
// the divider only an evaluate that moves a limit, and in_ready is high
// only while the sequencer is idle. The window scan reads one entry a cycle
// from the single memory port. A result held in the output register does
// not block the next input; a later result waits in its final step until
// the receiver takes the pending one.
// Reset (arst_n low) empties the window to all zero samples, clears the
// sums, the scale to 1 and the axis limits to zero, and restores the
// threshold registers to 11 and 3 tenths.
module window_stats_autorange (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  cfg_we,
	input  logic [wsa_pkg::CFG_IDX_W-1:0]         cfg_index,
	input  logic [wsa_pkg::CFG_W-1:0]             cfg_data,
	input  logic                                  in_valid,
	output logic                                  in_ready,
	input  logic                                  opcode,
	input  logic signed [wsa_pkg::SAMPLE_W-1:0]   sample,
	output logic                                  out_valid,
	input  logic                                  out_ready,
	output logic signed [wsa_pkg::SAMPLE_W-1:0]   mean,
	output logic [wsa_pkg::VAR_W-1:0]             variance,
	output logic signed [wsa_pkg::SAMPLE_W-1:0]   window_min,
	output logic signed [wsa_pkg::SAMPLE_W-1:0]   window_max,
	output logic [wsa_pkg::GRID_W-1:0]            grid_step,
	output logic signed [wsa_pkg::LIMIT_W-1:0]    axis_top,
	output logic signed [wsa_pkg::LIMIT_W-1:0]    axis_bottom,
	output logic                                  scale_saturated
);

	localparam int SW = wsa_pkg::SAMPLE_W;
	localparam int LW = wsa_pkg::LIMIT_W;
	localparam int MW = wsa_pkg::MUL_W;
	localparam logic [wsa_pkg::DIV_N-1:0] DIV_N_ZERO = '0;

	wsa_pkg::state_t state_q, state_d;

	logic signed [SW-1:0]              samp_q, old_q, min_q, max_q;
	logic                              eval_q;
	logic signed [wsa_pkg::SUM_W-1:0]  sum_q;
	logic [wsa_pkg::SQ_W-1:0]          sq_q;
	logic [wsa_pkg::ADDR_W-1:0]        oldest_q;
	wsa_pkg::scale_t                   scale_q;
	logic signed [LW-1:0]              top_q, bot_q;
	logic [4:0]                        grow_q;
	logic [3:0]                        shrink_q;
	logic                              sat_q, grow_hit_q;
	logic [wsa_pkg::CNT_W-1:0]         cnt_q;
	logic [SW:0]                       range_q;
	logic signed [wsa_pkg::PROD_W-1:0] prod_q;
	logic                              out_valid_q;

	logic signed [MW-1:0]              mul_a, mul_b;
	wsa_pkg::mem_req_t                 mem_req;
	logic signed [SW-1:0]              mem_value;
	wsa_pkg::div_req_t                 div_req;
	wsa_pkg::div_rsp_t                 div_rsp;

	logic [wsa_pkg::GRID_W-1:0]        grid;
	logic [wsa_pkg::GRID_W+3:0]        g20;
	logic [LW-1:0]                     span28;
	logic [31:0]                       g_far;
	logic signed [31:0]                g_s, d4, e4;
	logic signed [29:0]                dtop, dbot;
	logic                              move_top, move_bot;
	logic [SW-1:0]                     mag_max, mag_min;
	logic signed [MW-1:0]              q_s;
	logic [28:0]                       range10;
	logic signed [wsa_pkg::PROD_W-1:0] range10_s;
	wsa_pkg::step_res_t                up_res;
	wsa_pkg::scale_t                   new_scale;
	logic [wsa_pkg::NUM_W-1:0]         num;
	logic                              out_free;

	wsa_window u_window (
		.clk      (clk),
		.arst_n   (arst_n),
		.req      (mem_req),
		.rd_value (mem_value)
	);

	wsa_divider u_divider (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (div_req),
		.rsp    (div_rsp)
	);

	// Grid and axis corridor quantities
	assign grid   = wsa_pkg::grid_value(scale_q);
	assign g20    = {grid, 4'b0000};
	assign span28 = LW'(g20 * wsa_pkg::GRID_LINES);
	assign g_far  = 32'(g20 * (3 * wsa_pkg::GRID_LINES));
	assign g_s    = $signed({12'b0, g20});
	assign dtop   = 30'(max_q) - 30'(top_q);
	assign dbot   = 30'(min_q) - 30'(bot_q);
	assign d4     = $signed({dtop, 2'b00});
	assign e4     = $signed({dbot, 2'b00});
	assign move_top = (d4 > g_s) || (d4 < -$signed(g_far));
	assign move_bot = (e4 < -g_s) || (e4 > $signed(g_far));
	assign mag_max  = max_q[SW-1] ? SW'(-max_q) : max_q;
	assign mag_min  = min_q[SW-1] ? SW'(-min_q) : min_q;
	assign q_s      = $signed({5'b0, div_rsp.quotient});

	// Threshold tests and scale step
	assign range10   = 29'(range_q) * 29'd10;
	assign range10_s = $signed({33'b0, range10});
	assign up_res    = grow_hit_q ? wsa_pkg::step_up(scale_q)
		: wsa_pkg::step_res_t'{sc: scale_q, sat: 1'b0};
	assign new_scale = (range10_s < prod_q) ? wsa_pkg::step_down(up_res.sc) : up_res.sc;

	// Variance numerator: N * square sum - sum squared
	assign num      = {sq_q, wsa_pkg::ADDR_W'(0)} - prod_q[wsa_pkg::NUM_W-1:0];
	assign out_free = !out_valid_q || out_ready;

	// Next state, shared multiplier operands, memory and divider requests
	always_comb begin
		state_d          = state_q;
		mul_a            = '0;
		mul_b            = '0;
		mem_req.we       = 1'b0;
		mem_req.addr     = oldest_q;
		mem_req.wdata    = samp_q;
		div_req.start    = 1'b0;
		div_req.dividend = DIV_N_ZERO;
		div_req.divisor  = 22'(g20) << 1;
		unique case (state_q)
			wsa_pkg::ST_IDLE: begin
				if (in_valid) begin
					state_d = opcode ? wsa_pkg::ST_E_SCAN : wsa_pkg::ST_P_RD;
				end
			end
			wsa_pkg::ST_P_RD: state_d = wsa_pkg::ST_P_SS;
			wsa_pkg::ST_P_SS: begin
				mul_a   = MW'(samp_q);
				mul_b   = MW'(samp_q);
				state_d = wsa_pkg::ST_P_OO;
			end
			wsa_pkg::ST_P_OO: begin
				mul_a   = MW'(old_q);
				mul_b   = MW'(old_q);
				state_d = wsa_pkg::ST_P_UPD;
			end
			wsa_pkg::ST_P_UPD: begin
				mem_req.we = 1'b1;
				state_d    = wsa_pkg::ST_F_SQ;
			end
			wsa_pkg::ST_E_SCAN: begin
				mem_req.addr = cnt_q[wsa_pkg::ADDR_W-1:0];
				if (cnt_q == wsa_pkg::CNT_W'(wsa_pkg::WINDOW_DEPTH)) begin
					state_d = wsa_pkg::ST_E_GMUL;
				end
			end
			wsa_pkg::ST_E_GMUL: begin
				mul_a   = $signed({26'b0, grow_q});
				mul_b   = $signed({3'b0, span28});
				state_d = wsa_pkg::ST_E_SMUL;
			end
			wsa_pkg::ST_E_SMUL: begin
				mul_a   = $signed({27'b0, shrink_q});
				mul_b   = $signed({3'b0, span28});
				state_d = wsa_pkg::ST_E_STEP;
			end
			wsa_pkg::ST_E_STEP: state_d = wsa_pkg::ST_E_TTEST;
			wsa_pkg::ST_E_TTEST: begin
				div_req.dividend = 26'({mag_max, 1'b0}) + 26'(g20);
				if (move_top) begin
					div_req.start = 1'b1;
					state_d       = wsa_pkg::ST_E_TDIV;
				end else begin
					state_d = wsa_pkg::ST_E_BTEST;
				end
			end
			wsa_pkg::ST_E_TDIV: begin
				if (div_rsp.done) begin
					state_d = wsa_pkg::ST_E_TMUL;
				end
			end
			wsa_pkg::ST_E_TMUL: begin
				mul_a   = (max_q[SW-1] ? -q_s : q_s) + MW'(1);
				mul_b   = $signed({11'b0, g20});
				state_d = wsa_pkg::ST_E_TSET;
			end
			wsa_pkg::ST_E_TSET: state_d = wsa_pkg::ST_E_BTEST;
			wsa_pkg::ST_E_BTEST: begin
				div_req.dividend = 26'({mag_min, 1'b0}) + 26'(g20);
				if (move_bot) begin
					div_req.start = 1'b1;
					state_d       = wsa_pkg::ST_E_BDIV;
				end else begin
					state_d = wsa_pkg::ST_F_SQ;
				end
			end
			wsa_pkg::ST_E_BDIV: begin
				if (div_rsp.done) begin
					state_d = wsa_pkg::ST_E_BMUL;
				end
			end
			wsa_pkg::ST_E_BMUL: begin
				mul_a   = (min_q[SW-1] ? -q_s : q_s) - MW'(1);
				mul_b   = $signed({11'b0, g20});
				state_d = wsa_pkg::ST_E_BSET;
			end
			wsa_pkg::ST_E_BSET: state_d = wsa_pkg::ST_F_SQ;
			wsa_pkg::ST_F_SQ: begin
				mul_a   = MW'(sum_q);
				mul_b   = MW'(sum_q);
				state_d = wsa_pkg::ST_F_OUT;
			end
			wsa_pkg::ST_F_OUT: begin
				mul_a = MW'(sum_q);
				mul_b = MW'(sum_q);
				if (out_free) begin
					state_d = wsa_pkg::ST_IDLE;
				end
			end
			default: state_d = wsa_pkg::ST_IDLE;
		endcase
	end

	// Shared multiplier, product registered
	always_ff @(posedge clk) begin
		prod_q <= mul_a * mul_b;
	end

	// Item datapath registers
	always_ff @(posedge clk) begin
		case (state_q)
			wsa_pkg::ST_IDLE: begin
				samp_q <= sample;
				eval_q <= opcode;
				min_q  <= '0;
				max_q  <= '0;
				cnt_q  <= '0;
			end
			wsa_pkg::ST_P_SS: old_q <= mem_value;
			wsa_pkg::ST_E_SCAN: begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == wsa_pkg::CNT_W'(1)) begin
					min_q <= mem_value;
					max_q <= mem_value;
				end else if (cnt_q != '0) begin
					if (mem_value > max_q) max_q <= mem_value;
					if (mem_value < min_q) min_q <= mem_value;
				end
			end
			wsa_pkg::ST_E_GMUL: range_q <= (SW+1)'(max_q) - (SW+1)'(min_q);
			wsa_pkg::ST_E_SMUL: grow_hit_q <= range10_s > prod_q;
			default: ;
		endcase
	end

	// Control, window state, scale, limits and configuration
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= wsa_pkg::ST_IDLE;
			sum_q    <= '0;
			sq_q     <= '0;
			oldest_q <= '0;
			scale_q  <= '{mant: wsa_pkg::MANT_1, dec: 3'd0};
			top_q    <= '0;
			bot_q    <= '0;
			sat_q    <= 1'b0;
			grow_q   <= wsa_pkg::GROW_RESET;
			shrink_q <= wsa_pkg::SHRINK_RESET;
		end else begin
			state_q <= state_d;
			if (cfg_we) begin
				unique case (cfg_index)
					wsa_pkg::REG_GROW:   grow_q   <= cfg_data[4:0];
					wsa_pkg::REG_SHRINK: shrink_q <= cfg_data[3:0];
					default: ;
				endcase
			end
			case (state_q)
				wsa_pkg::ST_IDLE: sat_q <= 1'b0;
				wsa_pkg::ST_P_OO: sq_q <= sq_q + prod_q[wsa_pkg::SQ_W-1:0];
				wsa_pkg::ST_P_UPD: begin
					sq_q  <= sq_q - prod_q[wsa_pkg::SQ_W-1:0];
					sum_q <= sum_q + wsa_pkg::SUM_W'(samp_q) - wsa_pkg::SUM_W'(old_q);
					if (oldest_q == wsa_pkg::ADDR_W'(wsa_pkg::WINDOW_DEPTH - 1)) begin
						oldest_q <= '0;
					end else begin
						oldest_q <= oldest_q + 1'b1;
					end
				end
				wsa_pkg::ST_E_STEP: begin
					scale_q <= new_scale;
					sat_q   <= up_res.sat;
				end
				wsa_pkg::ST_E_TSET: begin
					top_q <= $signed(prod_q[LW-1:0]);
					bot_q <= $signed(prod_q[LW-1:0] - span28);
				end
				wsa_pkg::ST_E_BSET: begin
					bot_q <= $signed(prod_q[LW-1:0]);
					top_q <= $signed(prod_q[LW-1:0] + span28);
				end
				default: ;
			endcase
		end
	end

	// Output register: load on the final step, drop once taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (state_q == wsa_pkg::ST_F_OUT && out_free) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == wsa_pkg::ST_F_OUT && out_free) begin
			mean            <= SW'(sum_q >>> wsa_pkg::ADDR_W);
			variance        <= num[wsa_pkg::NUM_W-1 -: wsa_pkg::VAR_W];
			window_min      <= eval_q ? min_q : '0;
			window_max      <= eval_q ? max_q : '0;
			grid_step       <= grid;
			axis_top        <= top_q;
			axis_bottom     <= bot_q;
			scale_saturated <= eval_q & sat_q;
		end
	end

	assign in_ready  = (state_q == wsa_pkg::ST_IDLE);
	assign out_valid = out_valid_q;

endmodule

[rtl/core/wsa_checker.sv]
module wsa_checker (
	input logic                                  clk,
	input logic                                  arst_n,
	input logic                                  in_valid,
	input logic                                  in_ready,
	input logic                                  out_valid,
	input logic                                  out_ready,
	input logic [wsa_pkg::GRID_W-1:0]            grid_step
);

	// Hold a result until the receiver takes it
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid)
		else $error("result dropped while stalled");

	// Drop ready for the transaction in progress
	assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("second transaction taken while busy");

	// Keep the grid inside the 1 to 50000 range
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> grid_step != '0 && grid_step <= 16'd50000)
		else $error("grid step out of range");

endmodule

bind window_stats_autorange wsa_checker u_wsa_checker (
	.clk             (clk),
	.arst_n          (arst_n),
	.in_valid        (in_valid),
	.in_ready        (in_ready),
	.out_valid       (out_valid),
	.out_ready       (out_ready),
	.grid_step       (grid_step)
);

[verif/tb_window_stats_autorange.sv]
module tb_window_stats_autorange;

	localparam logic OP_PUSH = 1'b0;
	localparam logic OP_EVAL = 1'b1;
	localparam int   DRAIN_CYCLES = 200;

	typedef struct {
		logic signed [wsa_pkg::SAMPLE_W-1:0] mean;
		logic [wsa_pkg::VAR_W-1:0]           variance;
		logic signed [wsa_pkg::SAMPLE_W-1:0] wmin;
		logic signed [wsa_pkg::SAMPLE_W-1:0] wmax;
		logic [wsa_pkg::GRID_W-1:0]          grid;
		logic signed [wsa_pkg::LIMIT_W-1:0]  top;
		logic signed [wsa_pkg::LIMIT_W-1:0]  bottom;
		logic                                sat;
	} stats_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_we = 1'b0;
	logic [wsa_pkg::CFG_IDX_W-1:0] cfg_index = wsa_pkg::REG_GROW;
	logic [wsa_pkg::CFG_W-1:0] cfg_data = '0;
	logic in_valid = 1'b0;
	logic in_ready;
	logic opcode = OP_PUSH;
	logic signed [wsa_pkg::SAMPLE_W-1:0] sample = '0;
	logic out_valid;
	logic out_ready = 1'b0;
	logic signed [wsa_pkg::SAMPLE_W-1:0] mean, window_min, window_max;
	logic [wsa_pkg::VAR_W-1:0] variance;
	logic [wsa_pkg::GRID_W-1:0] grid_step;
	logic signed [wsa_pkg::LIMIT_W-1:0] axis_top, axis_bottom;
	logic scale_saturated;

	// Mirror of the block state
	longint win_q[wsa_pkg::WINDOW_DEPTH];
	int     head_idx;
	longint sum_acc;
	longint unsigned sq_acc;
	int     mant_code, dec_code;
	longint top_lim, bot_lim;
	int     grow_tenths, shrink_tenths;

	stats_t pending_results[$];
	int     errors = 0;
	bit     steady_flow = 1'b0;
	int     stall_left = 0;

	window_stats_autorange u_dut (.*);

	always #5 clk = ~clk;

	initial begin
		#(20_000_000);
		$display("tb_window_stats_autorange: done, errors");
		$finish;
	end

	// Receiver stalls: mostly short, sometimes long, none in steady stretches
	always @(posedge clk) begin
		if (steady_flow) begin
			out_ready <= 1'b1;
			stall_left = 0;
		end else if (stall_left > 0) begin
			out_ready <= 1'b0;
			stall_left--;
		end else begin
			case ($urandom_range(0, 19))
				0: begin
					out_ready <= 1'b0;
					stall_left = $urandom_range(10, 60);
				end
				1, 2, 3: begin
					out_ready <= 1'b0;
					stall_left = $urandom_range(0, 2);
				end
				default: out_ready <= 1'b1;
			endcase
		end
	end

	function automatic longint grid_units(int m, int d);
		longint mv, dv;
		mv = (m == 1) ? 2 : (m == 2) ? 5 : 1;
		dv = (d == 0) ? 1 : (d == 1) ? 10 : (d == 2) ? 100 : (d == 3) ? 1000 : 10000;
		return mv * dv;
	endfunction

	function automatic longint wrap28(longint v);
		logic signed [wsa_pkg::LIMIT_W-1:0] t;
		t = v[wsa_pkg::LIMIT_W-1:0];
		return longint'(t);
	endfunction

	// Round to nearest multiple count, halves away from zero
	function automatic longint nearest_div(longint a, longint g);
		longint mag, q;
		mag = (a < 0) ? -a : a;
		q = (2 * mag + g) / (2 * g);
		return (a < 0) ? -q : q;
	endfunction

	task automatic reset_mirror();
		foreach (win_q[i]) win_q[i] = 0;
		head_idx = 0;
		sum_acc = 0;
		sq_acc = 0;
		mant_code = 0;
		dec_code = 0;
		top_lim = 0;
		bot_lim = 0;
		grow_tenths = 11;
		shrink_tenths = 3;
	endtask

	// Work out the result of one accepted transaction and advance the mirror
	task automatic predict_stats(input logic op, input longint s, output stats_t r);
		longint lo, hi, range, span, g, old_s, us;
		longint unsigned num;
		bit sat;
		lo = 0;
		hi = 0;
		sat = 1'b0;
		if (op == OP_PUSH) begin
			old_s = win_q[head_idx];
			sum_acc += s - old_s;
			sq_acc = sq_acc + longint'(s * s) - longint'(old_s * old_s);
			win_q[head_idx] = s;
			head_idx = (head_idx + 1) % wsa_pkg::WINDOW_DEPTH;
		end else begin
			lo = win_q[0];
			hi = win_q[0];
			for (int i = 1; i < wsa_pkg::WINDOW_DEPTH; i++) begin
				if (win_q[i] > hi) hi = win_q[i];
				if (win_q[i] < lo) lo = win_q[i];
			end
			range = hi - lo;
			span = grid_units(mant_code, dec_code) * wsa_pkg::GRID_LINES * 16;
			// Grow first, then shrink, both against the old span
			if (range * 10 > grow_tenths * span) begin
				if (mant_code < 2) begin
					mant_code++;
				end else if (dec_code >= 4) begin
					dec_code = 4;
					sat = 1'b1;
				end else begin
					mant_code = 0;
					dec_code++;
				end
			end
			if (range * 10 < shrink_tenths * span) begin
				if (mant_code > 0) begin
					mant_code--;
				end else if (dec_code > 0) begin
					mant_code = 2;
					dec_code--;
				end
			end
			g = grid_units(mant_code, dec_code) * 16;
			if ((hi - top_lim) * 4 > g ||
					(hi - top_lim) * 4 < -3 * wsa_pkg::GRID_LINES * g) begin
				top_lim = wrap28((nearest_div(hi, g) + 1) * g);
				bot_lim = wrap28(top_lim - g * wsa_pkg::GRID_LINES);
			end
			if ((lo - bot_lim) * 4 < -g ||
					(lo - bot_lim) * 4 > 3 * wsa_pkg::GRID_LINES * g) begin
				bot_lim = wrap28((nearest_div(lo, g) - 1) * g);
				top_lim = wrap28(bot_lim + g * wsa_pkg::GRID_LINES);
			end
		end
		us = (sum_acc < 0) ? -sum_acc : sum_acc;
		num = longint'(wsa_pkg::WINDOW_DEPTH) * sq_acc - longint'(us * us);
		r.mean     = wsa_pkg::SAMPLE_W'(sum_acc >>> 6);
		r.variance = wsa_pkg::VAR_W'(num / (wsa_pkg::WINDOW_DEPTH * wsa_pkg::WINDOW_DEPTH));
		r.wmin     = wsa_pkg::SAMPLE_W'(lo);
		r.wmax     = wsa_pkg::SAMPLE_W'(hi);
		r.grid     = wsa_pkg::GRID_W'(grid_units(mant_code, dec_code));
		r.top      = wsa_pkg::LIMIT_W'(top_lim);
		r.bottom   = wsa_pkg::LIMIT_W'(bot_lim);
		r.sat      = sat;
	endtask

	task automatic compare_field(input string name, input logic [63:0] exp_v,
			input logic [63:0] act_v);
		if (exp_v !== act_v) begin
			$display("%0t: %s mismatch, expected %h, got %h", $time, name, exp_v, act_v);
			errors++;
		end
	endtask

	// Check every result transaction against the oldest prediction
	always @(posedge clk) begin
		stats_t e;
		if (out_valid && out_ready) begin
			if (pending_results.size() == 0) begin
				$display("%0t: unexpected result, expected none, got mean %h", $time, mean);
				errors++;
			end else begin
				e = pending_results.pop_front();
				compare_field("mean", e.mean, mean);
				compare_field("variance", e.variance, variance);
				compare_field("window_min", e.wmin, window_min);
				compare_field("window_max", e.wmax, window_max);
				compare_field("grid_step", e.grid, grid_step);
				compare_field("axis_top", e.top, axis_top);
				compare_field("axis_bottom", e.bottom, axis_bottom);
				compare_field("scale_saturated", e.sat, scale_saturated);
			end
		end
	end

	// Offer one transaction and hold it until accepted; valid stays high
	task automatic send_item(input logic op, input logic signed [wsa_pkg::SAMPLE_W-1:0] s);
		stats_t r;
		in_valid <= 1'b1;
		opcode <= op;
		sample <= s;
		do @(posedge clk); while (!in_ready);
		predict_stats(op, longint'(s), r);
		pending_results.push_back(r);
		idle_gap();
	endtask

	task automatic idle_gap();
		int n;
		n = 0;
		if (!steady_flow) begin
			case ($urandom_range(0, 9))
				0, 1, 2:    n = $urandom_range(1, 3);
				3:          n = $urandom_range(10, 40);
				default:    n = 0;
			endcase
		end
		if (n > 0) begin
			in_valid <= 1'b0;
			repeat (n) @(posedge clk);
		end
	endtask

	task automatic drain();
		in_valid <= 1'b0;
		while (pending_results.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic write_thresholds(input int grow, input int shrink);
		drain();
		cfg_we <= 1'b1;
		cfg_index <= wsa_pkg::REG_GROW;
		cfg_data <= wsa_pkg::CFG_W'(grow);
		@(posedge clk);
		cfg_index <= wsa_pkg::REG_SHRINK;
		cfg_data <= wsa_pkg::CFG_W'(shrink);
		@(posedge clk);
		cfg_we <= 1'b0;
		grow_tenths = grow & 31;
		shrink_tenths = shrink & 15;
		@(posedge clk);
	endtask

	function automatic logic signed [wsa_pkg::SAMPLE_W-1:0] pick_sample(int cls, int base);
		case (cls)
			0:       return wsa_pkg::SAMPLE_W'(base + $urandom_range(0, 127) - 64);
			1:       return wsa_pkg::SAMPLE_W'(base + $urandom_range(0, 8191) - 4096);
			2:       return wsa_pkg::SAMPLE_W'($urandom_range(0, 1 << 19) - (1 << 18));
			default: return wsa_pkg::SAMPLE_W'($urandom);
		endcase
	endfunction

	// Empty window, extremes of the sample and the ceiling of the scale
	task automatic test_directed();
		steady_flow = 1'b1;
		send_item(OP_EVAL, '0);
		send_item(OP_PUSH, 24'sh7FFFFF);
		send_item(OP_PUSH, 24'sh800000);
		send_item(OP_PUSH, 24'sh000001);
		send_item(OP_PUSH, 24'shFFFFFF);
		repeat (15) send_item(OP_EVAL, 24'sh5A5A5A);
		steady_flow = 1'b0;
	endtask

	// Bursts of correlated pushes, each closed by an evaluate
	task automatic test_random_phase(input int grow, input int shrink, input int count);
		int cls, base, burst, sent;
		write_thresholds(grow, shrink);
		sent = 0;
		while (sent < count) begin
			cls = $urandom_range(0, 5);
			if (cls > 3) cls = 0;
			base = $urandom_range(0, 1 << 22) - (1 << 21);
			steady_flow = ($urandom_range(0, 7) == 0);
			burst = $urandom_range(1, 20);
			repeat (burst) begin
				if ($urandom_range(0, 15) == 0)
					send_item(OP_PUSH, wsa_pkg::SAMPLE_W'($urandom));
				else
					send_item(OP_PUSH, pick_sample(cls, base));
			end
			send_item(OP_EVAL, wsa_pkg::SAMPLE_W'($urandom));
			sent += burst + 1;
		end
		steady_flow = 1'b0;
	endtask

	initial begin
		reset_mirror();
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed();
		test_random_phase(11, 3, 100);
		test_random_phase(30, 9, 100);
		test_random_phase(10, 1, 100);
		test_random_phase(0, 0, 90);
		test_random_phase(31, 15, 90);
		test_random_phase(2, 9, 90);
		test_random_phase(20, 5, 90);
		drain();
		if (errors == 0)
			$display("tb_window_stats_autorange: done, clean");
		else
			$display("tb_window_stats_autorange: done, errors");
		$finish;
	end

endmodule

[filelist.f]
rtl/core/wsa_pkg.sv
rtl/core/wsa_window.sv
rtl/core/wsa_divider.sv
rtl/core/window_stats_autorange.sv
rtl/core/wsa_checker.sv
verif/tb_window_stats_autorange.sv
